// ===== rtl/b2n_pkg.sv =====
// shared types, constants and coefficients of the bgra to nv12 converter
`timescale 1ns / 1ps

package b2n_pkg;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = CFG_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // line store word: red, green, blue pair sums
  localparam int PAIR_W = 9;
  localparam int LINE_W = 3 * PAIR_W;

  // luma coefficients
  localparam logic [7:0]  CY_R      = 8'd66;
  localparam logic [7:0]  CY_G      = 8'd129;
  localparam logic [7:0]  CY_B      = 8'd25;
  localparam logic [15:0] Y_ROUND   = 16'd128;
  localparam logic [7:0]  LUMA_OFS  = 8'd16;

  // chroma coefficients
  localparam int CSUM_W = 18;
  localparam logic signed [8:0] CU_R = -9'sd38;
  localparam logic signed [8:0] CU_G = -9'sd74;
  localparam logic signed [8:0] CU_B = 9'sd112;
  localparam logic signed [8:0] CV_R = 9'sd112;
  localparam logic signed [8:0] CV_G = -9'sd94;
  localparam logic signed [8:0] CV_B = -9'sd18;
  // rounding plus the 128 offset, placed in bits 15:8, so the word stays positive
  localparam logic signed [CSUM_W-1:0] CHROMA_BIAS = 18'sd32896;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       chroma_valid;
    logic       end_of_line;
    logic       end_of_frame;
    logic       setup_error;
  } result_t;

  // 2x2 block averages
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } avg_t;

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] v;
  } uv_t;

endpackage

// ===== rtl/b2n_stream_if.sv =====
// valid/ready stream channel carrying one word of payload
`timescale 1ns / 1ps

interface b2n_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/b2n_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module b2n_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/b2n_chroma.sv =====
// bt.601 u and v from the averaged 2x2 block
`timescale 1ns / 1ps

module b2n_chroma (
  input  b2n_pkg::avg_t avg,
  output b2n_pkg::uv_t  uv
);

  logic signed [b2n_pkg::CSUM_W-1:0] r_s, g_s, b_s;
  logic signed [b2n_pkg::CSUM_W-1:0] sum_u, sum_v;

  assign r_s = signed'({10'd0, avg.r});
  assign g_s = signed'({10'd0, avg.g});
  assign b_s = signed'({10'd0, avg.b});

  assign sum_u = b2n_pkg::CU_R * r_s + b2n_pkg::CU_G * g_s + b2n_pkg::CU_B * b_s
               + b2n_pkg::CHROMA_BIAS;
  assign sum_v = b2n_pkg::CV_R * r_s + b2n_pkg::CV_G * g_s + b2n_pkg::CV_B * b_s
               + b2n_pkg::CHROMA_BIAS;

  // biased sum always lies in 0..65535, so the floor shift needs no clamp
  assign uv.u = sum_u[15:8];
  assign uv.v = sum_v[15:8];

endmodule

// ===== rtl/bgra_to_nv12_converter_core.sv =====
// top level of the bgra to nv12 converter: counters, line store and pipeline
//
//  channel   dir  handshake            word
//  in_pix    in   valid/ready          pixel_t  blue, green, red
//  out_res   out  valid/ready          result_t luma, u, v, flags
//  cfg       in   cfg_we (no ready)    cfg_index, cfg_data (13 bits)
//
// one pixel per clock while out_res takes results; registered through the input
// register, the luma/average stage and the result register
// the line store is one ram with registered read; the read for a block is
// issued on its even column, the data is held until the odd column arrives
// rst_n is synchronous; a config write restarts the frame at row 0, column 0
// stalls on out_res ripple back through the stages to in_pix.ready
`timescale 1ns / 1ps

module bgra_to_nv12_converter_core #(
  parameter int MAX_WIDTH  = b2n_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = b2n_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  b2n_stream_if.sink                    in_pix,
  b2n_stream_if.source                  out_res,
  input  logic                          cfg_we,
  input  logic [b2n_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [b2n_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW         = b2n_pkg::CMP_W;
  localparam int PW         = b2n_pkg::PAIR_W;

  // configuration
  logic [b2n_pkg::CFG_W-1:0] width_r, height_r;
  logic                      size_ok;

  // position of the next pixel
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] row_eff;
  logic             out_of_frame;
  logic             last_col, last_row;

  // stage 1: input register
  logic                  s1_v_r;
  b2n_pkg::pixel_t       s1_pix_r;
  logic                  s1_col_odd_r, s1_row_odd_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic                  s1_eol_r, s1_eof_r, s1_err_r;

  // stage 2: luma and block averages
  logic                  s2_v_r;
  logic [7:0]            s2_luma_r;
  b2n_pkg::avg_t         s2_avg_r;
  logic                  s2_cvalid_r, s2_eol_r, s2_eof_r, s2_err_r;

  // stage 3: result register
  logic                  out_v_r;
  b2n_pkg::result_t      out_data_r;

  // held even column pixel
  b2n_pkg::pixel_t       held_r;

  logic in_fire, s1_fire, s1_en, s2_en, s3_en;

  // line store
  logic                        ram_we, ram_re;
  logic [b2n_pkg::LINE_W-1:0]  ram_wdata, ram_rdata;

  logic [PW-1:0]   sum_r, sum_g, sum_b;
  logic [PW:0]     quad_r, quad_g, quad_b;
  logic [15:0]     y_sum;
  logic [7:0]      luma;
  b2n_pkg::avg_t   avg;
  b2n_pkg::uv_t    uv;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= b2n_pkg::FRAME_WIDTH_RST;
      height_r <= b2n_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        b2n_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
        b2n_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // even, nonzero and within the line store / row counter range
  assign size_ok = (width_r != '0) && !width_r[0] && ({1'b0, width_r} <= CW'(MAX_WIDTH)) &&
                   (height_r != '0) && !height_r[0] &&
                   ({1'b0, height_r} <= CW'(MAX_HEIGHT));

  // -------------------------------------------------------------- handshake
  assign s3_en   = !out_v_r || out_res.ready;
  assign s2_en   = !s2_v_r || s3_en;
  assign s1_en   = !s1_v_r || s2_en;
  assign s1_fire = s1_v_r && s2_en;

  assign in_pix.ready = s1_en;
  assign in_fire      = in_pix.valid && s1_en;

  // --------------------------------------------------------------- counters
  // counters outside the frame restart it
  assign out_of_frame = (CW'(col_r) >= {1'b0, width_r}) || (CW'(row_r) >= {1'b0, height_r});
  assign col_eff      = out_of_frame ? '0 : col_r;
  assign row_eff      = out_of_frame ? '0 : row_r;
  assign last_col     = (CW'(col_eff) + CW'(1)) >= {1'b0, width_r};
  assign last_row     = (CW'(row_eff) + CW'(1)) >= {1'b0, height_r};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire && size_ok) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : ROW_W'(row_eff + ROW_W'(1));
      end else begin
        col_nxt = COL_W'(col_eff + COL_W'(1));
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ----------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r     <= in_pix.data;
      s1_col_odd_r <= col_eff[0];
      s1_row_odd_r <= row_eff[0];
      s1_addr_r    <= ADDR_W'(col_eff >> 1);
      s1_eol_r     <= last_col;
      s1_eof_r     <= last_col && last_row;
      s1_err_r     <= !size_ok;
    end
  end

  // held pixel of the even column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s1_fire && !s1_err_r && !s1_col_odd_r) begin
      held_r <= s1_pix_r;
    end
  end

  // horizontal pair sums
  assign sum_r = PW'(held_r.red)   + PW'(s1_pix_r.red);
  assign sum_g = PW'(held_r.green) + PW'(s1_pix_r.green);
  assign sum_b = PW'(held_r.blue)  + PW'(s1_pix_r.blue);

  // write on odd column of even rows, read ahead on every even column
  assign ram_we    = s1_fire && !s1_err_r && s1_col_odd_r && !s1_row_odd_r;
  assign ram_re    = s1_fire && !s1_err_r && !s1_col_odd_r;
  assign ram_wdata = {sum_r, sum_g, sum_b};

  b2n_ram #(
    .WIDTH (b2n_pkg::LINE_W),
    .DEPTH (LINE_DEPTH),
    .AW    (ADDR_W)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (s1_addr_r),
    .rdata (ram_rdata)
  );

  // four pixel sums, truncated by 4
  assign quad_r = (PW+1)'(sum_r) + (PW+1)'(ram_rdata[3*PW-1:2*PW]);
  assign quad_g = (PW+1)'(sum_g) + (PW+1)'(ram_rdata[2*PW-1:PW]);
  assign quad_b = (PW+1)'(sum_b) + (PW+1)'(ram_rdata[PW-1:0]);
  assign avg.r  = quad_r[PW:2];
  assign avg.g  = quad_g[PW:2];
  assign avg.b  = quad_b[PW:2];

  // luma, never above 235 so no clamp
  assign y_sum = b2n_pkg::CY_R * s1_pix_r.red + b2n_pkg::CY_G * s1_pix_r.green
               + b2n_pkg::CY_B * s1_pix_r.blue + b2n_pkg::Y_ROUND;
  assign luma  = y_sum[15:8] + b2n_pkg::LUMA_OFS;

  // ----------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_luma_r   <= s1_err_r ? '0 : luma;
      s2_avg_r    <= avg;
      s2_cvalid_r <= !s1_err_r && s1_col_odd_r && s1_row_odd_r;
      s2_eol_r    <= !s1_err_r && s1_eol_r;
      s2_eof_r    <= !s1_err_r && s1_eof_r;
      s2_err_r    <= s1_err_r;
    end
  end

  b2n_chroma u_chroma (
    .avg (s2_avg_r),
    .uv  (uv)
  );

  // ----------------------------------------------------------- result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_en) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_v_r) begin
      out_data_r.luma         <= s2_luma_r;
      out_data_r.chroma_u     <= s2_cvalid_r ? uv.u : '0;
      out_data_r.chroma_v     <= s2_cvalid_r ? uv.v : '0;
      out_data_r.chroma_valid <= s2_cvalid_r;
      out_data_r.end_of_line  <= s2_eol_r;
      out_data_r.end_of_frame <= s2_eof_r;
      out_data_r.setup_error  <= s2_err_r;
    end
  end

  assign out_res.valid = out_v_r;
  assign out_res.data  = out_data_r;

endmodule

// ===== test/bgra_to_nv12_converter_core_tb.sv =====
// self-checking testbench of the bgra to nv12 converter core: directed table, then random frames
`timescale 1ns / 1ps

module bgra_to_nv12_converter_core_tb;

  localparam int CLK_HALF     = 5;
  localparam int RST_CYCLES   = 6;
  // pipe is three stages deep; settle a little longer before touching config
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LINE_DEPTH   = b2n_pkg::MAX_WIDTH_DEF / 2;
  localparam int ITEMS_PER_MODE = 540;
  localparam int LONG_HOLD    = 400;

  // indexes past the register list: no effect except a frame restart
  localparam logic [b2n_pkg::CFG_IDX_W-1:0] REG_SPARE    = 2'd2;
  localparam logic [b2n_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_e;
  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [b2n_pkg::CFG_IDX_W-1:0]  idx;
    logic [b2n_pkg::CFG_W-1:0]      val;
    b2n_pkg::pixel_t                pix;
    logic                           typed;
    b2n_pkg::result_t               res;
  } dir_row_t;

  localparam b2n_pkg::pixel_t PX_BLACK = '{8'h00, 8'h00, 8'h00};
  localparam b2n_pkg::pixel_t PX_WHITE = '{8'hff, 8'hff, 8'hff};
  localparam b2n_pkg::pixel_t PX_BLUE  = '{8'hff, 8'h00, 8'h00};
  localparam b2n_pkg::pixel_t PX_GREEN = '{8'h00, 8'hff, 8'h00};
  localparam b2n_pkg::pixel_t PX_RED   = '{8'h00, 8'h00, 8'hff};

  localparam b2n_pkg::result_t RES_NONE       = '0;
  localparam b2n_pkg::result_t RES_BLACK      = '{8'd16, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam b2n_pkg::result_t RES_WHITE      = '{8'd235, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam b2n_pkg::result_t RES_WHITE_EOL  = '{8'd235, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam b2n_pkg::result_t RES_WHITE_LAST = '{8'd235, 8'd128, 8'd128, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam b2n_pkg::result_t RES_SETUP_ERR  = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1};

  // directed stimulus; rows without a typed result are checked by the predictor
  localparam dir_row_t DIR_TAB [26] = '{
    // reset size 1920x1080: black and white at the top left, no line end
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_BLACK, 1'b1, RES_BLACK},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_WHITE},
    // smallest frame, one white 2x2 block: neutral chroma on the last pixel
    '{ROW_CFG, b2n_pkg::REG_FRAME_WIDTH,  13'd2,    PX_BLACK, 1'b0, RES_NONE},
    '{ROW_CFG, b2n_pkg::REG_FRAME_HEIGHT, 13'd2,    PX_BLACK, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_WHITE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_WHITE_EOL},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_WHITE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_WHITE_LAST},
    // unusable sizes: odd and too wide, zero, just above the maximum, then odd and zero heights
    '{ROW_CFG, b2n_pkg::REG_FRAME_WIDTH,  13'd8191, PX_BLACK, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_SETUP_ERR},
    '{ROW_CFG, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_BLACK, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_WHITE, 1'b1, RES_SETUP_ERR},
    '{ROW_CFG, b2n_pkg::REG_FRAME_WIDTH,  13'd4098, PX_BLACK, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_RED,   1'b1, RES_SETUP_ERR},
    '{ROW_CFG, b2n_pkg::REG_FRAME_WIDTH,  13'd2,    PX_BLACK, 1'b0, RES_NONE},
    '{ROW_CFG, b2n_pkg::REG_FRAME_HEIGHT, 13'd5,    PX_BLACK, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_BLUE,  1'b1, RES_SETUP_ERR},
    '{ROW_CFG, b2n_pkg::REG_FRAME_HEIGHT, 13'd0,    PX_BLACK, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_GREEN, 1'b1, RES_SETUP_ERR},
    '{ROW_CFG, b2n_pkg::REG_FRAME_HEIGHT, 13'd2,    PX_BLACK, 1'b0, RES_NONE},
    // half a block, then a write to an unused index restarts the frame
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_BLUE,  1'b0, RES_NONE},
    '{ROW_CFG, REG_SPARE_HI,              13'd0,    PX_BLACK, 1'b0, RES_NONE},
    // saturated primaries and black, one per pixel of the block
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_BLUE,  1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_RED,   1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_GREEN, 1'b0, RES_NONE},
    '{ROW_PIX, b2n_pkg::REG_FRAME_WIDTH,  13'd0,    PX_BLACK, 1'b0, RES_NONE}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [b2n_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [b2n_pkg::CFG_W-1:0]     cfg_data = '0;

  b2n_stream_if #(.T(b2n_pkg::pixel_t))  pix_if ();
  b2n_stream_if #(.T(b2n_pkg::result_t)) res_if ();

  bgra_to_nv12_converter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  idle_mode_e       idle_mode = IDLE_RX_HEAVY;
  bit               hold_req = 1'b0;
  int               hold_left = 0;
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  b2n_pkg::result_t want_q [$];

  // converter state as the block should hold it
  logic [b2n_pkg::CFG_W-1:0]  fw_cur;
  logic [b2n_pkg::CFG_W-1:0]  fh_cur;
  logic [b2n_pkg::LINE_W-1:0] pair_sums [LINE_DEPTH];
  b2n_pkg::pixel_t            held_px;
  int                         col_pos;
  int                         row_pos;

  function automatic logic [7:0] sat_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // add half, floor shift, then offset to the middle of the byte range
  function automatic logic [7:0] chroma_of(input int sum);
    return sat_byte(((sum + 128) >>> 8) + 128);
  endfunction

  // one pixel in, one result word out; advances the frame position
  function automatic b2n_pkg::result_t convert_pixel(input b2n_pkg::pixel_t p);
    b2n_pkg::result_t           r;
    int                         sr;
    int                         sg;
    int                         sb;
    int                         ar;
    int                         ag;
    int                         ab;
    logic [b2n_pkg::LINE_W-1:0] e;
    bit                         size_ok;
    r = '0;
    size_ok = fw_cur != 0 && !fw_cur[0] && fw_cur <= b2n_pkg::MAX_WIDTH_DEF &&
              fh_cur != 0 && !fh_cur[0] && fh_cur <= b2n_pkg::MAX_HEIGHT_DEF;
    if (!size_ok) begin
      r.setup_error = 1'b1;
      return r;
    end
    if (col_pos >= fw_cur || row_pos >= fh_cur) begin
      col_pos = 0;
      row_pos = 0;
    end
    r.luma = sat_byte(((66 * int'(p.red) + 129 * int'(p.green) +
                        25 * int'(p.blue) + 128) >> 8) + 16);
    if (col_pos % 2 == 0) begin
      held_px = p;
    end else begin
      sr = int'(held_px.red) + int'(p.red);
      sg = int'(held_px.green) + int'(p.green);
      sb = int'(held_px.blue) + int'(p.blue);
      if (row_pos % 2 == 0) begin
        pair_sums[col_pos / 2] = {9'(sr), 9'(sg), 9'(sb)};
      end else begin
        e  = pair_sums[col_pos / 2];
        ar = (sr + int'(e[26:18])) >> 2;
        ag = (sg + int'(e[17:9])) >> 2;
        ab = (sb + int'(e[8:0])) >> 2;
        r.chroma_u     = chroma_of(-38 * ar - 74 * ag + 112 * ab);
        r.chroma_v     = chroma_of(112 * ar - 94 * ag - 18 * ab);
        r.chroma_valid = 1'b1;
      end
    end
    if (col_pos + 1 >= fw_cur) begin
      r.end_of_line = 1'b1;
      col_pos = 0;
      if (row_pos + 1 >= fh_cur) begin
        r.end_of_frame = 1'b1;
        row_pos = 0;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  function automatic int tx_idle_pct();
    case (idle_mode)
      IDLE_RX_HEAVY: return 35;
      IDLE_TX_HEAVY: return 75;
      default:       return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (idle_mode)
      IDLE_RX_HEAVY: return 75;
      IDLE_TX_HEAVY: return 35;
      default:       return 0;
    endcase
  endfunction

  // mostly uniform bytes, sometimes a rail value
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic b2n_pkg::pixel_t rand_pixel();
    b2n_pkg::pixel_t p;
    p.blue  = rand_byte();
    p.green = rand_byte();
    p.red   = rand_byte();
    return p;
  endfunction

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // offer one pixel word, wait for it to be taken, queue its expected result
  task automatic send_pixel(input b2n_pkg::pixel_t p, input bit typed,
                            input b2n_pkg::result_t typed_res);
    b2n_pkg::result_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct()) begin
      pix_if.valid = 1'b0;
      pix_if.data  = rand_pixel();
      @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.data  = p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    want = convert_pixel(p);
    want_q.push_back(typed ? typed_res : want);
  endtask

  task automatic send_run(input int count);
    repeat (count) send_pixel(rand_pixel(), 1'b0, RES_NONE);
  endtask

  // stop offering and let every outstanding result come out
  task automatic drain_out();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [b2n_pkg::CFG_IDX_W-1:0] idx,
                           input logic [b2n_pkg::CFG_W-1:0] val);
    drain_out();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      b2n_pkg::REG_FRAME_WIDTH:  fw_cur = val;
      b2n_pkg::REG_FRAME_HEIGHT: fh_cur = val;
      default: ;
    endcase
    // any write restarts the frame
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
  endtask

  // receiver: random back-pressure, or a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(0, 99) >= rx_idle_pct());
      end
    end
  end

  // result checker: every word taken is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    b2n_pkg::result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (want_q.size() == 0) begin
        $display("%0t: result word with none expected: %h", $time, res_if.data);
        err_cnt++;
      end else begin
        want = want_q.pop_front();
        check_field("luma", res_if.data.luma, want.luma);
        check_field("chroma_u", res_if.data.chroma_u, want.chroma_u);
        check_field("chroma_v", res_if.data.chroma_v, want.chroma_v);
        check_field("chroma_valid", res_if.data.chroma_valid, want.chroma_valid);
        check_field("end_of_line", res_if.data.end_of_line, want.end_of_line);
        check_field("end_of_frame", res_if.data.end_of_frame, want.end_of_frame);
        check_field("setup_error", res_if.data.setup_error, want.setup_error);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, want_q.size());
      $display("bgra_to_nv12_converter_core test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t                  row;
    int                        set_no;
    int                        mode_items;
    int                        pick;
    int                        part;
    logic [b2n_pkg::CFG_W-1:0] w_sel;
    logic [b2n_pkg::CFG_W-1:0] h_sel;
    logic [b2n_pkg::CFG_W-1:0] bad_val;

    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    fw_cur  = b2n_pkg::FRAME_WIDTH_RST;
    fh_cur  = b2n_pkg::FRAME_HEIGHT_RST;
    held_px = '0;
    col_pos = 0;
    row_pos = 0;

    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DIR_TAB); i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_CFG) cfg_write(row.idx, row.val);
      else send_pixel(row.pix, row.typed, row.res);
    end

    // random frames under each idling pattern in turn
    for (int m = 0; m < 3; m++) begin
      drain_out();
      idle_mode  = idle_mode_e'(m);
      mode_items = 0;
      set_no     = 0;
      while (mode_items < ITEMS_PER_MODE) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // unusable size: zero, odd, or above the maximum
          case ($urandom_range(0, 2))
            0:       bad_val = '0;
            1:       bad_val = 13'($urandom_range(0, 4095) * 2 + 1);
            default: bad_val = 13'($urandom_range(4097, 8191));
          endcase
          cfg_write(($urandom_range(0, 1) != 0) ? b2n_pkg::REG_FRAME_HEIGHT :
                                                  b2n_pkg::REG_FRAME_WIDTH,
                    bad_val);
          send_run($urandom_range(1, 4));
        end else begin
          w_sel = 13'(2 * $urandom_range(1, 10));
          h_sel = 13'(2 * $urandom_range(1, 4));
          cfg_write(b2n_pkg::REG_FRAME_WIDTH, w_sel);
          cfg_write(b2n_pkg::REG_FRAME_HEIGHT, h_sel);
          // stall the output for a long stretch while pixels keep coming
          if (idle_mode == IDLE_NONE && set_no == 0) hold_req = 1'b1;
          if (pick == 1) begin
            // frame cut short by a write to an unused index
            part = $urandom_range(1, int'(w_sel) * int'(h_sel) - 1);
            send_run(part);
            cfg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE,
                      13'($urandom_range(0, 8191)));
            mode_items += part;
          end
          part = int'(w_sel) * int'(h_sel) * $urandom_range(1, 2);
          send_run(part);
          mode_items += part;
          set_no++;
        end
      end
    end

    // widest line: the start of a full-width line
    cfg_write(b2n_pkg::REG_FRAME_WIDTH, 13'd4096);
    cfg_write(b2n_pkg::REG_FRAME_HEIGHT, 13'd2);
    send_run(96);
    // tallest frame, only its first lines
    cfg_write(b2n_pkg::REG_FRAME_WIDTH, 13'd2);
    cfg_write(b2n_pkg::REG_FRAME_HEIGHT, 13'd4096);
    send_run(12);

    drain_out();
    if (err_cnt == 0) begin
      $display("bgra_to_nv12_converter_core test passed");
    end else begin
      $display("bgra_to_nv12_converter_core test failed");
    end
    $finish;
  end

endmodule
